// ===== rtl/cwcm_pkg.sv =====
`timescale 1ns / 1ps

package cwcm_pkg;

    // Build-time window strides and kernel bound
    localparam int STRIDE_ROWS = 1;
    localparam int STRIDE_COLS = 1;
    localparam int MAX_KERNEL  = 8;

    // Field widths
    localparam int KW    = 4;   // kernel size register
    localparam int GW    = 11;  // grid size register
    localparam int PW    = 10;  // pixel coordinate
    localparam int IDXW  = 20;  // center index
    localparam int SW    = 13;  // signed window origin arithmetic
    localparam int CNTW  = 4;   // centers per axis, 0..MAX_KERNEL
    localparam int SELW  = 3;   // list slot select
    localparam int PHW   = 3;   // stride phase
    localparam int DW    = 12;  // offset origin for the stride phase
    localparam int PCW   = 4;   // microcode step counter

    // Stride phase by reciprocal multiply: q = (d * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 16;
    localparam int RECIPW      = RECIP_SHIFT + 1;
    localparam logic [RECIPW-1:0] RECIP_ROWS = RECIPW'((1 << RECIP_SHIFT) / STRIDE_ROWS);
    localparam logic [RECIPW-1:0] RECIP_COLS = RECIPW'((1 << RECIP_SHIFT) / STRIDE_COLS);
    localparam logic [KW-1:0] STRIDE_R = KW'(STRIDE_ROWS);
    localparam logic [KW-1:0] STRIDE_C = KW'(STRIDE_COLS);
    // Bias that keeps the first origin non-negative before the phase step
    localparam logic [SW-1:0] BIAS_R = SW'(MAX_KERNEL * STRIDE_ROWS);
    localparam logic [SW-1:0] BIAS_C = SW'(MAX_KERNEL * STRIDE_COLS);

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_KERNEL_HEIGHT = 3'd0,
        CFG_KERNEL_WIDTH  = 3'd1,
        CFG_SOURCE_HEIGHT = 3'd2,
        CFG_SOURCE_WIDTH  = 3'd3,
        CFG_DEST_HEIGHT   = 3'd4,
        CFG_DEST_WIDTH    = 3'd5,
        CFG_SAME_PADDING  = 3'd6,
        CFG_DEST_IS_GRID  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [KW-1:0] kernel_height;
        logic [KW-1:0] kernel_width;
        logic [GW-1:0] source_height;
        logic [GW-1:0] source_width;
        logic [GW-1:0] dest_height;
        logic [GW-1:0] dest_width;
        logic          same_padding;
        logic          dest_is_grid;
    } cfg_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_ACCEPT    = 3'd0,
        OP_PREP_Q    = 3'd1,
        OP_PREP_R    = 3'd2,
        OP_SCAN      = 3'd3,
        OP_DECIDE    = 3'd4,
        OP_EMIT_LIST = 3'd5,
        OP_EMIT_FLAT = 3'd6
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS    = 3'd0,
        C_IN_ACC    = 3'd1,
        C_SCAN_DONE = 3'd2,
        C_SINGLE    = 3'd3,
        C_LIST_DONE = 3'd4,
        C_OUT_SENT  = 3'd5
    } cond_t;

    typedef enum logic {
        AX_ROW = 1'b0,
        AX_COL = 1'b1
    } axis_t;

    // One control word
    typedef struct packed {
        op_t            op;
        axis_t          axis;
        cond_t          cond;
        logic [PCW-1:0] tgt_t;
        logic [PCW-1:0] tgt_f;
    } uword_t;

    // Status back to the sequencer
    typedef struct packed {
        logic in_acc;
        logic scan_done;
        logic single;
        logic list_done;
        logic out_sent;
    } stat_t;

    // Program steps
    localparam logic [PCW-1:0] PC_ACCEPT    = 4'd0;
    localparam logic [PCW-1:0] PC_ROW_PREQ  = 4'd1;
    localparam logic [PCW-1:0] PC_ROW_PRER  = 4'd2;
    localparam logic [PCW-1:0] PC_ROW_SCAN  = 4'd3;
    localparam logic [PCW-1:0] PC_COL_PREQ  = 4'd4;
    localparam logic [PCW-1:0] PC_COL_PRER  = 4'd5;
    localparam logic [PCW-1:0] PC_COL_SCAN  = 4'd6;
    localparam logic [PCW-1:0] PC_DECIDE    = 4'd7;
    localparam logic [PCW-1:0] PC_EMIT_LIST = 4'd8;
    localparam logic [PCW-1:0] PC_EMIT_FLAT = 4'd9;

    // Control store
    function automatic uword_t ucode_rom(input logic [PCW-1:0] pc);
        uword_t w;
        case (pc)
            PC_ACCEPT:    w = '{OP_ACCEPT,    AX_ROW, C_IN_ACC,    PC_ROW_PREQ,  PC_ACCEPT};
            PC_ROW_PREQ:  w = '{OP_PREP_Q,    AX_ROW, C_ALWAYS,    PC_ROW_PRER,  PC_ROW_PRER};
            PC_ROW_PRER:  w = '{OP_PREP_R,    AX_ROW, C_ALWAYS,    PC_ROW_SCAN,  PC_ROW_SCAN};
            PC_ROW_SCAN:  w = '{OP_SCAN,      AX_ROW, C_SCAN_DONE, PC_COL_PREQ,  PC_ROW_SCAN};
            PC_COL_PREQ:  w = '{OP_PREP_Q,    AX_COL, C_ALWAYS,    PC_COL_PRER,  PC_COL_PRER};
            PC_COL_PRER:  w = '{OP_PREP_R,    AX_COL, C_ALWAYS,    PC_COL_SCAN,  PC_COL_SCAN};
            PC_COL_SCAN:  w = '{OP_SCAN,      AX_COL, C_SCAN_DONE, PC_DECIDE,    PC_COL_SCAN};
            PC_DECIDE:    w = '{OP_DECIDE,    AX_ROW, C_SINGLE,    PC_EMIT_FLAT, PC_EMIT_LIST};
            PC_EMIT_LIST: w = '{OP_EMIT_LIST, AX_ROW, C_LIST_DONE, PC_ACCEPT,    PC_EMIT_LIST};
            PC_EMIT_FLAT: w = '{OP_EMIT_FLAT, AX_ROW, C_OUT_SENT,  PC_ACCEPT,    PC_EMIT_FLAT};
            default:      w = '{OP_ACCEPT,    AX_ROW, C_ALWAYS,    PC_ACCEPT,    PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/conv_window_center_mapper.sv =====
`timescale 1ns / 1ps
// Steps per item: accept, then for rows and then columns two phase steps and one scan step
// per kernel tap (kh, kw = saturated kernel sizes), then a decide step and the emit steps.
// Results per item: n = 1..64, one per cycle while the receiver is ready; a new item is
// accepted only after the last result of the current item has been loaded for output.
// Reset (aresetn low, synchronous): step counter to accept, output empty,
// registers to kernel 3x3, grid sizes 1, valid padding, grid destination.

module conv_window_center_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] pixel_row, [19:10] pixel_col
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] center_index
    output logic [1:0]  m_tuser,   // [0] covered, [1] center_valid
    output logic        m_tlast
);

    cwcm_pkg::cfg_t   cfg_reg, cfg_next;
    cwcm_pkg::uword_t ctl;
    cwcm_pkg::stat_t  stat;
    logic             covered, center_valid;
    logic [cwcm_pkg::IDXW-1:0] center_index;

    // Configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                cwcm_pkg::CFG_KERNEL_HEIGHT: cfg_next.kernel_height = cfg_wdata[3:0];
                cwcm_pkg::CFG_KERNEL_WIDTH:  cfg_next.kernel_width  = cfg_wdata[3:0];
                cwcm_pkg::CFG_SOURCE_HEIGHT: cfg_next.source_height = cfg_wdata;
                cwcm_pkg::CFG_SOURCE_WIDTH:  cfg_next.source_width  = cfg_wdata;
                cwcm_pkg::CFG_DEST_HEIGHT:   cfg_next.dest_height   = cfg_wdata;
                cwcm_pkg::CFG_DEST_WIDTH:    cfg_next.dest_width    = cfg_wdata;
                cwcm_pkg::CFG_SAME_PADDING:  cfg_next.same_padding  = cfg_wdata[0];
                cwcm_pkg::CFG_DEST_IS_GRID:  cfg_next.dest_is_grid  = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kernel_height <= 4'd3;
            cfg_reg.kernel_width  <= 4'd3;
            cfg_reg.source_height <= 11'd1;
            cfg_reg.source_width  <= 11'd1;
            cfg_reg.dest_height   <= 11'd1;
            cfg_reg.dest_width    <= 11'd1;
            cfg_reg.same_padding  <= 1'b0;
            cfg_reg.dest_is_grid  <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cwcm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    cwcm_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .ctl            (ctl),
        .s_tvalid       (s_tvalid),
        .in_row         (s_tdata[9:0]),
        .in_col         (s_tdata[19:10]),
        .m_tready       (m_tready),
        .stat           (stat),
        .m_valid        (m_tvalid),
        .m_covered      (covered),
        .m_center_valid (center_valid),
        .m_center_index (center_index),
        .m_last         (m_tlast)
    );

    // Item ready only on the accept step
    assign s_tready = (ctl.op == cwcm_pkg::OP_ACCEPT);
    assign m_tdata  = {4'd0, center_index};
    assign m_tuser  = {center_valid, covered};

endmodule

// ===== rtl/cwcm_seq.sv =====
`timescale 1ns / 1ps

module cwcm_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  cwcm_pkg::stat_t stat,
    output cwcm_pkg::uword_t ctl
);

    logic [cwcm_pkg::PCW-1:0] pc_reg;
    logic [cwcm_pkg::PCW-1:0] pc_next;
    logic                     take;

    // Fetch the current control word
    assign ctl = cwcm_pkg::ucode_rom(pc_reg);

    // Evaluate the jump condition
    always_comb begin
        case (ctl.cond)
            cwcm_pkg::C_ALWAYS:    take = 1'b1;
            cwcm_pkg::C_IN_ACC:    take = stat.in_acc;
            cwcm_pkg::C_SCAN_DONE: take = stat.scan_done;
            cwcm_pkg::C_SINGLE:    take = stat.single;
            cwcm_pkg::C_LIST_DONE: take = stat.list_done;
            cwcm_pkg::C_OUT_SENT:  take = stat.out_sent;
            default:               take = 1'b1;
        endcase
        pc_next = take ? ctl.tgt_t : ctl.tgt_f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= cwcm_pkg::PC_ACCEPT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= cwcm_pkg::PC_EMIT_FLAT)
        else $error("step counter left the program");

    a_accept_enters_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == cwcm_pkg::OP_ACCEPT && stat.in_acc) |=> (pc_reg == cwcm_pkg::PC_ROW_PREQ))
        else $error("accepted item did not start the row scan");

    a_emit_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == cwcm_pkg::OP_EMIT_LIST && stat.list_done) |=> (pc_reg == cwcm_pkg::PC_ACCEPT))
        else $error("final center did not return to accept");

endmodule

// ===== rtl/cwcm_datapath.sv =====
`timescale 1ns / 1ps

module cwcm_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cwcm_pkg::cfg_t             cfg,
    input  cwcm_pkg::uword_t           ctl,
    input  logic                       s_tvalid,
    input  logic [cwcm_pkg::PW-1:0]    in_row,
    input  logic [cwcm_pkg::PW-1:0]    in_col,
    input  logic                       m_tready,
    output cwcm_pkg::stat_t            stat,
    output logic                       m_valid,
    output logic                       m_covered,
    output logic                       m_center_valid,
    output logic [cwcm_pkg::IDXW-1:0]  m_center_index,
    output logic                       m_last
);

    localparam int SW   = cwcm_pkg::SW;
    localparam int GW   = cwcm_pkg::GW;
    localparam int KW   = cwcm_pkg::KW;
    localparam int DW   = cwcm_pkg::DW;
    localparam int CNTW = cwcm_pkg::CNTW;
    localparam int SELW = cwcm_pkg::SELW;
    localparam int PHW  = cwcm_pkg::PHW;
    localparam int PRW  = DW + cwcm_pkg::RECIPW;

    // Latched pixel
    logic [cwcm_pkg::PW-1:0] prow_reg, prow_next;
    logic [cwcm_pkg::PW-1:0] pcol_reg, pcol_next;

    // Scan state
    logic signed [SW-1:0] o_reg, o_next;
    logic [SELW-1:0]      j_reg, j_next;
    logic [PHW-1:0]       phase_reg, phase_next;
    logic [DW-1:0]        q_reg, q_next;
    logic [GW-1:0]        last_c_reg, last_c_next;
    logic [CNTW-1:0]      row_cnt_reg, row_cnt_next;
    logic [CNTW-1:0]      col_cnt_reg, col_cnt_next;
    logic [GW-1:0]        row_list_reg [cwcm_pkg::MAX_KERNEL];
    logic [GW-1:0]        col_list_reg [cwcm_pkg::MAX_KERNEL];
    logic                 list_we;

    // Emit state
    logic [SELW-1:0] ri_reg, ri_next;
    logic [SELW-1:0] ci_reg, ci_next;

    // Output register
    logic                           m_valid_reg, m_valid_next;
    logic                           covered_reg, covered_next;
    logic                           cvalid_reg, cvalid_next;
    logic [cwcm_pkg::IDXW-1:0]      index_reg, index_next;
    logic                           last_reg, last_next;

    // Per-axis operands
    logic [cwcm_pkg::PW-1:0] ax_p;
    logic [GW-1:0]           ax_size;
    logic [KW-1:0]           ax_kraw;
    logic [KW-1:0]           ax_k;
    logic [GW-1:0]           ax_dsize;
    logic [KW-1:0]           ax_stride;
    logic [cwcm_pkg::RECIPW-1:0] ax_recip;
    logic [SW-1:0]           ax_bias;
    logic [CNTW-1:0]         ax_cnt;
    logic [2:0]              half;

    logic signed [SW-1:0] p_s, size_s, k_s, half_s, start_s, end_s, o0_s, o_base, d0_s;
    logic signed [SW-1:0] c_s, dmax_s;
    logic [DW-1:0]        d0p;
    logic [PRW-1:0]       qprod;
    logic [15:0]          qs_prod;
    logic [SW-1:0]        r_raw;
    logic [PHW-1:0]       r_fix;
    logic [GW-1:0]        c_clamp;
    logic                 hit, dup;

    // Emit operands
    logic [GW-1:0]        dw_eff;
    logic [GW-1:0]        rsel, csel;
    logic [2*GW-1:0]      idx_full;
    logic                 emit_last;
    logic                 out_load;
    logic                 single;

    // Select the axis operands and saturate kernel and destination sizes
    always_comb begin
        if (ctl.axis == cwcm_pkg::AX_COL) begin
            ax_p      = pcol_reg;
            ax_size   = cfg.source_width;
            ax_kraw   = cfg.kernel_width;
            ax_dsize  = (cfg.dest_width == '0) ? GW'(1) : cfg.dest_width;
            ax_stride = cwcm_pkg::STRIDE_C;
            ax_recip  = cwcm_pkg::RECIP_COLS;
            ax_bias   = cwcm_pkg::BIAS_C;
            ax_cnt    = col_cnt_reg;
        end else begin
            ax_p      = prow_reg;
            ax_size   = cfg.source_height;
            ax_kraw   = cfg.kernel_height;
            ax_dsize  = (cfg.dest_height == '0) ? GW'(1) : cfg.dest_height;
            ax_stride = cwcm_pkg::STRIDE_R;
            ax_recip  = cwcm_pkg::RECIP_ROWS;
            ax_bias   = cwcm_pkg::BIAS_R;
            ax_cnt    = row_cnt_reg;
        end
        if (ax_kraw == '0) begin
            ax_k = KW'(1);
        end else if (ax_kraw > KW'(cwcm_pkg::MAX_KERNEL)) begin
            ax_k = KW'(cwcm_pkg::MAX_KERNEL);
        end else begin
            ax_k = ax_kraw;
        end
        half = ax_k[3:1];
    end

    // Window origin range for this axis
    always_comb begin
        p_s     = $signed({3'b000, ax_p});
        size_s  = $signed({2'b00, ax_size});
        k_s     = $signed({9'd0, ax_k});
        half_s  = $signed({10'd0, half});
        start_s = cfg.same_padding ? -half_s : '0;
        end_s   = cfg.same_padding ? (size_s - SW'(1) + half_s) : (size_s - k_s);
        o0_s    = p_s - k_s + SW'(1);
        o_base  = (ctl.op == cwcm_pkg::OP_PREP_Q) ? o0_s : o_reg;
        d0_s    = o_base - start_s + $signed(ax_bias);
        d0p     = d0_s[DW-1:0];
    end

    // Stride phase of the first origin: quotient, then remainder with one fix-up
    always_comb begin
        qprod   = PRW'(d0p) * PRW'(ax_recip);
        q_next  = qprod[cwcm_pkg::RECIP_SHIFT +: DW];
        qs_prod = 16'(q_reg) * 16'(ax_stride);
        r_raw   = SW'(d0p) - qs_prod[SW-1:0];
        if (r_raw >= SW'(ax_stride)) begin
            r_fix = PHW'(r_raw - SW'(ax_stride));
        end else begin
            r_fix = PHW'(r_raw);
        end
    end

    // Covering test and clamped center for the current origin
    always_comb begin
        hit    = ({1'b0, ax_p} < ax_size) && (o_reg >= start_s) && (o_reg <= end_s)
                 && (phase_reg == '0);
        c_s    = o_reg + half_s;
        dmax_s = $signed({2'b00, ax_dsize}) - SW'(1);
        if (c_s < 0) begin
            c_clamp = '0;
        end else if (c_s > dmax_s) begin
            c_clamp = dmax_s[GW-1:0];
        end else begin
            c_clamp = c_s[GW-1:0];
        end
        dup = (ax_cnt != '0) && (c_clamp == last_c_reg);
    end

    // Center index of the current row/column pair
    always_comb begin
        dw_eff    = (cfg.dest_width == '0) ? GW'(1) : cfg.dest_width;
        rsel      = row_list_reg[ri_reg];
        csel      = col_list_reg[ci_reg];
        idx_full  = rsel * dw_eff + (2*GW)'(csel);
        emit_last = ({1'b0, ri_reg} == row_cnt_reg - CNTW'(1))
                    && ({1'b0, ci_reg} == col_cnt_reg - CNTW'(1));
        out_load  = !m_valid_reg || m_tready;
        single    = (row_cnt_reg == '0) || (col_cnt_reg == '0) || !cfg.dest_is_grid;
    end

    // Next state per operation
    always_comb begin
        prow_next    = prow_reg;
        pcol_next    = pcol_reg;
        o_next       = o_reg;
        j_next       = j_reg;
        phase_next   = phase_reg;
        last_c_next  = last_c_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        ri_next      = ri_reg;
        ci_next      = ci_reg;
        list_we      = 1'b0;
        covered_next = covered_reg;
        cvalid_next  = cvalid_reg;
        index_next   = index_reg;
        last_next    = last_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;

        case (ctl.op)
            cwcm_pkg::OP_ACCEPT: begin
                if (s_tvalid) begin
                    prow_next = in_row;
                    pcol_next = in_col;
                end
            end
            cwcm_pkg::OP_PREP_Q: begin
                o_next = o0_s;
                j_next = SELW'(ax_k - KW'(1));
                if (ctl.axis == cwcm_pkg::AX_COL) begin
                    col_cnt_next = '0;
                end else begin
                    row_cnt_next = '0;
                end
            end
            cwcm_pkg::OP_PREP_R: begin
                phase_next = r_fix;
            end
            cwcm_pkg::OP_SCAN: begin
                o_next = o_reg + SW'(1);
                j_next = j_reg - SELW'(1);
                if ({1'b0, phase_reg} == ax_stride - KW'(1)) begin
                    phase_next = '0;
                end else begin
                    phase_next = phase_reg + PHW'(1);
                end
                if (hit && !dup && (ax_cnt < CNTW'(cwcm_pkg::MAX_KERNEL))) begin
                    list_we     = 1'b1;
                    last_c_next = c_clamp;
                    if (ctl.axis == cwcm_pkg::AX_COL) begin
                        col_cnt_next = col_cnt_reg + CNTW'(1);
                    end else begin
                        row_cnt_next = row_cnt_reg + CNTW'(1);
                    end
                end
            end
            cwcm_pkg::OP_DECIDE: begin
                ri_next = '0;
                ci_next = '0;
            end
            cwcm_pkg::OP_EMIT_LIST: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    covered_next = 1'b1;
                    cvalid_next  = 1'b1;
                    index_next   = idx_full[cwcm_pkg::IDXW-1:0];
                    last_next    = emit_last;
                    if ({1'b0, ci_reg} == col_cnt_reg - CNTW'(1)) begin
                        ci_next = '0;
                        ri_next = ri_reg + SELW'(1);
                    end else begin
                        ci_next = ci_reg + SELW'(1);
                    end
                end
            end
            cwcm_pkg::OP_EMIT_FLAT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    covered_next = (row_cnt_reg != '0) && (col_cnt_reg != '0);
                    cvalid_next  = 1'b0;
                    index_next   = '0;
                    last_next    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        prow_reg    <= prow_next;
        pcol_reg    <= pcol_next;
        o_reg       <= o_next;
        j_reg       <= j_next;
        phase_reg   <= phase_next;
        q_reg       <= q_next;
        last_c_reg  <= last_c_next;
        ri_reg      <= ri_next;
        ci_reg      <= ci_next;
        covered_reg <= covered_next;
        cvalid_reg  <= cvalid_next;
        index_reg   <= index_next;
        last_reg    <= last_next;
    end

    // Center lists, at most one slot written per scan step
    always_ff @(posedge aclk) begin
        if (list_we) begin
            if (ctl.axis == cwcm_pkg::AX_COL) begin
                col_list_reg[col_cnt_reg[SELW-1:0]] <= c_clamp;
            end else begin
                row_list_reg[row_cnt_reg[SELW-1:0]] <= c_clamp;
            end
        end
    end

    assign stat.in_acc    = s_tvalid;
    assign stat.scan_done = (j_reg == '0);
    assign stat.single    = single;
    assign stat.list_done = out_load && emit_last;
    assign stat.out_sent  = out_load;

    assign m_valid        = m_valid_reg;
    assign m_covered      = covered_reg;
    assign m_center_valid = cvalid_reg;
    assign m_center_index = index_reg;
    assign m_last         = last_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_cnt_reg <= CNTW'(cwcm_pkg::MAX_KERNEL)) && (col_cnt_reg <= CNTW'(cwcm_pkg::MAX_KERNEL)))
        else $error("center list overflow");

    a_list_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == cwcm_pkg::OP_EMIT_LIST) |-> (row_cnt_reg != '0 && col_cnt_reg != '0))
        else $error("center emission with an empty list");

    a_center_covered: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && cvalid_reg) |-> covered_reg)
        else $error("center item without coverage");

    a_flat_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == cwcm_pkg::OP_EMIT_FLAT && out_load) |=> (m_valid_reg && last_reg))
        else $error("single result not marked last");

endmodule

// ===== test/conv_window_center_mapper_tb.sv =====
`timescale 1ns / 1ps

module conv_window_center_mapper_tb;

    import cwcm_pkg::*;

    // One result item as the block should emit it
    typedef struct packed {
        logic            covered;
        logic            center_valid;
        logic [IDXW-1:0] center_index;
        logic            last;
    } center_item_t;

    // Scoreboard: register shadow, center predictor and queue of expected results
    class center_tracker;
        center_item_t  pending_centers[$];
        int            errors;
        logic [KW-1:0] kern_h, kern_w;
        logic [GW-1:0] src_h, src_w, dst_h, dst_w;
        logic          same_pad, grid_mode;

        function new();
            errors    = 0;
            kern_h    = 3;
            kern_w    = 3;
            src_h     = 1;
            src_w     = 1;
            dst_h     = 1;
            dst_w     = 1;
            same_pad  = 1'b0;
            grid_mode = 1'b1;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [GW-1:0] v);
            case (idx)
                CFG_KERNEL_HEIGHT: kern_h    = v[KW-1:0];
                CFG_KERNEL_WIDTH:  kern_w    = v[KW-1:0];
                CFG_SOURCE_HEIGHT: src_h     = v;
                CFG_SOURCE_WIDTH:  src_w     = v;
                CFG_DEST_HEIGHT:   dst_h     = v;
                CFG_DEST_WIDTH:    dst_w     = v;
                CFG_SAME_PADDING:  same_pad  = v[0];
                CFG_DEST_IS_GRID:  grid_mode = v[0];
                default: ;
            endcase
        endfunction

        // Kernel sizes outside 1..MAX_KERNEL saturate
        function int clip_kernel(logic [KW-1:0] k);
            if (k < 1) return 1;
            if (k > MAX_KERNEL) return MAX_KERNEL;
            return int'(k);
        endfunction

        // Distinct clamped centers along one axis, ascending; empty if uncovered
        function void axis_window_centers(int p, int size, int k, int stride, int dsize,
                                          output int cl[$]);
            int half, org_lo, org_hi, o, c;
            cl.delete();
            half   = k / 2;
            org_lo = same_pad ? -half : 0;
            org_hi = same_pad ? (size - 1 + half) : (size - k);
            if (p >= size) return;
            for (int j = k - 1; j >= 0; j--) begin
                o = p - j;
                if (o < org_lo || o > org_hi) continue;
                if (((o - org_lo) % stride) != 0) continue;
                c = o + half;
                if (c < 0) c = 0;
                if (c > dsize - 1) c = dsize - 1;
                if (cl.size() > 0 && cl[$] == c) continue;
                if (cl.size() < MAX_KERNEL) cl.push_back(c);
            end
        endfunction

        // Accepted pixel: queue up every result it should produce
        function void note_pixel(logic [PW-1:0] row, logic [PW-1:0] col);
            int           rows[$], cols[$];
            int           dh, dw;
            logic [31:0]  lin;
            center_item_t e;
            dh = (dst_h == 0) ? 1 : int'(dst_h);
            dw = (dst_w == 0) ? 1 : int'(dst_w);
            axis_window_centers(int'(row), int'(src_h), clip_kernel(kern_h), STRIDE_ROWS,
                                dh, rows);
            axis_window_centers(int'(col), int'(src_w), clip_kernel(kern_w), STRIDE_COLS,
                                dw, cols);
            // uncovered or flat mode: one flag-only result
            if (rows.size() == 0 || cols.size() == 0 || !grid_mode) begin
                e.covered      = (rows.size() > 0 && cols.size() > 0);
                e.center_valid = 1'b0;
                e.center_index = '0;
                e.last         = 1'b1;
                pending_centers.push_back(e);
                return;
            end
            foreach (rows[i]) begin
                foreach (cols[j]) begin
                    lin            = rows[i] * dw + cols[j];
                    e.covered      = 1'b1;
                    e.center_valid = 1'b1;
                    e.center_index = lin[IDXW-1:0];
                    e.last         = (i == rows.size() - 1 && j == cols.size() - 1);
                    pending_centers.push_back(e);
                end
            end
        endfunction

        function void check_center(logic [23:0] data, logic [1:0] flags, logic tail);
            center_item_t e;
            if (pending_centers.size() == 0) begin
                $display("%0t: result with none expected: tdata %h tuser %b tlast %b",
                         $time, data, flags, tail);
                errors++;
                return;
            end
            e = pending_centers.pop_front();
            if (flags[0] !== e.covered) begin
                $display("%0t: covered expected %b actual %b", $time, e.covered, flags[0]);
                errors++;
            end
            if (flags[1] !== e.center_valid) begin
                $display("%0t: center_valid expected %b actual %b",
                         $time, e.center_valid, flags[1]);
                errors++;
            end
            if (data !== 24'(e.center_index)) begin
                $display("%0t: center_index expected %h actual %h",
                         $time, 24'(e.center_index), data);
                errors++;
            end
            if (tail !== e.last) begin
                $display("%0t: last expected %b actual %b", $time, e.last, tail);
                errors++;
            end
        endfunction
    endclass

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_we    = 1'b0;
    logic [2:0]    cfg_index = CFG_KERNEL_HEIGHT;
    logic [GW-1:0] cfg_wdata = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [23:0]   s_tdata   = '0;   // [9:0] pixel_row, [19:10] pixel_col
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [23:0]   m_tdata;          // [19:0] center_index
    logic [1:0]    m_tuser;          // [0] covered, [1] center_valid
    logic          m_tlast;

    center_tracker tracker;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            random_sent    = 0;

    conv_window_center_mapper DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_center(m_tdata, m_tuser, m_tlast);
        end
    end

    // Sender: optional gap, then hold the pixel until it is taken
    task automatic send_pixel(input logic [PW-1:0] row, input logic [PW-1:0] col);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tdata  <= {4'b0, col, row};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_pixel(row, col);
        @(negedge aclk);
    endtask

    // Stop sending and let every expected result come out
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (tracker.pending_centers.size() > 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [GW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        tracker.set_reg(idx, v);
        @(negedge aclk);
    endtask

    task automatic apply_config(input logic [KW-1:0] kh, input logic [KW-1:0] kw,
                                input logic [GW-1:0] sh, input logic [GW-1:0] sw,
                                input logic [GW-1:0] dh, input logic [GW-1:0] dw,
                                input logic same, input logic grid);
        settle();
        write_reg(CFG_KERNEL_HEIGHT, GW'(kh));
        write_reg(CFG_KERNEL_WIDTH,  GW'(kw));
        write_reg(CFG_SOURCE_HEIGHT, sh);
        write_reg(CFG_SOURCE_WIDTH,  sw);
        write_reg(CFG_DEST_HEIGHT,   dh);
        write_reg(CFG_DEST_WIDTH,    dw);
        write_reg(CFG_SAME_PADDING,  GW'(same));
        write_reg(CFG_DEST_IS_GRID,  GW'(grid));
        cfg_we <= 1'b0;
    endtask

    // Mostly small grids so edges get hit; some full size, oversized and zero
    function automatic logic [GW-1:0] rand_grid();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return GW'($urandom_range(1, 24));
        if (pick < 85) return GW'($urandom_range(25, 1024));
        if (pick < 93) return GW'(1024);
        if (pick < 97) return GW'($urandom_range(1025, 2047));
        return '0;
    endfunction

    function automatic logic [KW-1:0] rand_kernel();
        if ($urandom_range(0, 99) < 88) return KW'($urandom_range(1, MAX_KERNEL));
        return KW'($urandom_range(0, 15));
    endfunction

    // Coordinate near the grid edges, inside the grid, or anywhere
    function automatic logic [PW-1:0] pick_coord(input logic [GW-1:0] size);
        int pick, lim, reach;
        pick = $urandom_range(0, 99);
        if (size == 0 || pick < 25) return PW'($urandom_range(0, 1023));
        lim   = (size > 1024) ? 1024 : int'(size);
        reach = (lim - 1 < 8) ? lim - 1 : 8;
        if (pick < 50) return PW'($urandom_range(0, reach));
        if (pick < 75) return PW'(lim - 1 - $urandom_range(0, reach));
        return PW'($urandom_range(0, lim - 1));
    endfunction

    task automatic set_idling(input int phase);
        case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endtask

    initial begin
        #4_000_000;
        $display("[conv_window_center_mapper] ERROR");
        $finish;
    end

    initial begin
        int group;
        int burst;
        int waited;
        tracker = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: 3x3 kernel on a 1x1 grid, no full window fits
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);

        // largest kernel, same padding, full 1024 grid: corners and a 64-center pixel
        apply_config(4'd8, 4'd8, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 1'b1, 1'b1);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd500, 10'd500);
        send_pixel(10'd1023, 10'd0);

        // flat mode, valid padding, pixels outside the source grid
        apply_config(4'd3, 4'd5, 11'd600, 11'd600, 11'd600, 11'd600, 1'b0, 1'b0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd599, 10'd599);
        send_pixel(10'd700, 10'd10);
        send_pixel(10'd10, 10'd1023);

        // kernel zero and oversize saturate, zero destination acts as 1x1
        apply_config(4'd0, 4'd15, 11'd16, 11'd16, 11'd0, 11'd0, 1'b1, 1'b1);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd15, 10'd15);
        send_pixel(10'd7, 10'd8);

        // oversized destination: center index wraps at 20 bits
        apply_config(4'd8, 4'd8, 11'd1024, 11'd1024, 11'd2047, 11'd2047, 1'b1, 1'b1);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1000, 10'd3);

        // kernel taller than the source under valid padding
        apply_config(4'd8, 4'd2, 11'd5, 11'd100, 11'd100, 11'd100, 1'b0, 1'b1);
        send_pixel(10'd2, 10'd50);

        // empty source rows, widest source
        apply_config(4'd1, 4'd1, 11'd0, 11'd2047, 11'd1024, 11'd1024, 1'b0, 1'b1);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd0, 10'd1023);

        // random settings, each with a burst of pixels under one idling phase
        group = 0;
        while (random_sent < 480) begin
            apply_config(rand_kernel(), rand_kernel(), rand_grid(), rand_grid(),
                         rand_grid(), rand_grid(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 99) < 80));
            set_idling(group % 4);
            burst = $urandom_range(12, 24);
            repeat (burst) begin
                send_pixel(pick_coord(tracker.src_h), pick_coord(tracker.src_w));
                random_sent++;
            end
            group++;
        end

        // drain, then allow for any stray late results
        s_tvalid <= 1'b0;
        waited = 0;
        while (tracker.pending_centers.size() > 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (32) @(negedge aclk);
        if (tracker.pending_centers.size() > 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, tracker.pending_centers.size());
            tracker.errors++;
        end

        if (tracker.errors == 0) begin
            $display("[conv_window_center_mapper] OK");
        end else begin
            $display("[conv_window_center_mapper] ERROR");
        end
        $finish;
    end

endmodule
